### design/lzwc_pkg.sv
`timescale 1ns / 1ps
// lzwc_pkg: shared types and constants of the lzw compressor
// no dependencies
package lzwc_pkg;

	localparam int BYTE_W     = 8;
	localparam int PACK_W     = 32;
	localparam int FIRST_FREE = 256;
	localparam int CNT_W      = 6;
	localparam int EMIT_W     = 3;
	localparam int MAX_OUT    = 7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_LOAD,
		ST_PROBE_RD,
		ST_PROBE_CHK,
		ST_EMIT_PUT,
		ST_EMIT_DRAIN,
		ST_FL_PUT,
		ST_FL_DRAIN,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		SEL_CUR,
		SEL_END,
		SEL_ZERO
	} code_sel_t;

	typedef struct packed {
		logic      accept;
		logic      mod_step;
		logic      probe_load;
		logic      mem_rd;
		logic      probe_adv;
		logic      hit;
		logic      add;
		logic      cur_from_ch;
		logic      put;
		code_sel_t code_sel;
		logic      drain;
		logic      in_flush;
		logic      tail;
		logic      clr_step;
		logic      stream_reset;
	} cmd_t;

	typedef struct packed {
		logic in_last;
		logic have_prefix;
		logic last;
		logic mod_done;
		logic rd_valid;
		logic rd_match;
		logic probe_exhausted;
		logic drain_pending;
		logic clr_done;
	} status_t;

endpackage

### design/lzwc_ctrl.sv
`timescale 1ns / 1ps
// lzwc_ctrl: controller state machine of the lzw compressor
// depends on lzwc_pkg
module lzwc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_ready,
	input  lzwc_pkg::status_t status,
	output lzwc_pkg::cmd_t    cmd
);

	lzwc_pkg::state_t    state_q, state_d;
	lzwc_pkg::code_sel_t fl_q, fl_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzwc_pkg::ST_CLEAR;
			fl_q    <= lzwc_pkg::SEL_CUR;
		end else begin
			state_q <= state_d;
			fl_q    <= fl_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		fl_d      = fl_q;
		cmd       = '0;
		cmd.code_sel = lzwc_pkg::SEL_CUR;
		src_ready = 1'b0;
		case (state_q)
			lzwc_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_done) state_d = lzwc_pkg::ST_IDLE;
			end
			lzwc_pkg::ST_IDLE: begin
				src_ready = 1'b1;
				fl_d      = lzwc_pkg::SEL_CUR;
				if (src_valid) begin
					cmd.accept = 1'b1;
					if (status.have_prefix) state_d = lzwc_pkg::ST_HASH;
					else if (status.in_last) state_d = lzwc_pkg::ST_FL_PUT;
				end
			end
			lzwc_pkg::ST_HASH: begin
				cmd.mod_step = 1'b1;
				if (status.mod_done) state_d = lzwc_pkg::ST_LOAD;
			end
			lzwc_pkg::ST_LOAD: begin
				cmd.probe_load = 1'b1;
				state_d = lzwc_pkg::ST_PROBE_RD;
			end
			lzwc_pkg::ST_PROBE_RD: begin
				cmd.mem_rd = 1'b1;
				state_d = lzwc_pkg::ST_PROBE_CHK;
			end
			lzwc_pkg::ST_PROBE_CHK: begin
				if (!status.rd_valid) begin
					cmd.add = 1'b1;
					state_d = lzwc_pkg::ST_EMIT_PUT;
				end else if (status.rd_match) begin
					cmd.hit = 1'b1;
					state_d = status.last ? lzwc_pkg::ST_FL_PUT : lzwc_pkg::ST_IDLE;
				end else if (status.probe_exhausted) begin
					state_d = lzwc_pkg::ST_EMIT_PUT;
				end else begin
					cmd.probe_adv = 1'b1;
					state_d = lzwc_pkg::ST_PROBE_RD;
				end
			end
			lzwc_pkg::ST_EMIT_PUT: begin
				cmd.put         = 1'b1;
				cmd.code_sel    = lzwc_pkg::SEL_CUR;
				cmd.cur_from_ch = 1'b1;
				state_d = lzwc_pkg::ST_EMIT_DRAIN;
			end
			lzwc_pkg::ST_EMIT_DRAIN: begin
				cmd.drain = 1'b1;
				if (!status.drain_pending)
					state_d = status.last ? lzwc_pkg::ST_FL_PUT : lzwc_pkg::ST_IDLE;
			end
			lzwc_pkg::ST_FL_PUT: begin
				cmd.put      = 1'b1;
				cmd.code_sel = fl_q;
				state_d = lzwc_pkg::ST_FL_DRAIN;
			end
			lzwc_pkg::ST_FL_DRAIN: begin
				cmd.drain    = 1'b1;
				cmd.in_flush = 1'b1;
				cmd.tail     = (fl_q == lzwc_pkg::SEL_ZERO);
				if (!status.drain_pending) begin
					case (fl_q)
						lzwc_pkg::SEL_CUR: begin
							fl_d    = lzwc_pkg::SEL_END;
							state_d = lzwc_pkg::ST_FL_PUT;
						end
						lzwc_pkg::SEL_END: begin
							fl_d    = lzwc_pkg::SEL_ZERO;
							state_d = lzwc_pkg::ST_FL_PUT;
						end
						default: begin
							state_d = lzwc_pkg::ST_FINISH;
						end
					endcase
				end
			end
			lzwc_pkg::ST_FINISH: begin
				cmd.stream_reset = 1'b1;
				state_d = lzwc_pkg::ST_CLEAR;
			end
			default: begin
				state_d = lzwc_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule

### design/lzwc_dp.sv
`timescale 1ns / 1ps
// lzwc_dp: datapath of the lzw compressor: dictionary memory, hash remainder
// unit, probe registers, code packer and output register; depends on lzwc_pkg
module lzwc_dp #(
	parameter int CODE_BITS  = 12,
	parameter int TABLE_SIZE = 5021,
	parameter int HASH_SHIFT = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lzwc_pkg::in_item_t  src_item,
	output lzwc_pkg::out_item_t dst_item,
	output logic                dst_valid,
	input  logic                dst_ready,
	input  lzwc_pkg::cmd_t      cmd,
	output lzwc_pkg::status_t   status
);

	localparam int IDX_W   = $clog2(TABLE_SIZE);
	localparam int VAL_W   = (lzwc_pkg::BYTE_W + HASH_SHIFT > CODE_BITS) ?
		lzwc_pkg::BYTE_W + HASH_SHIFT : CODE_BITS;
	localparam int RW      = (VAL_W > IDX_W) ? VAL_W : IDX_W;
	localparam int QB      = (VAL_W - IDX_W + 1 > 1) ? VAL_W - IDX_W + 1 : 1;
	localparam int MK_W    = (QB > 1) ? $clog2(QB) : 1;
	localparam int ENTRY_W = 1 + 2 * CODE_BITS + lzwc_pkg::BYTE_W;
	localparam int PAD_W   = lzwc_pkg::PACK_W - CODE_BITS;

	// entry layout: valid, code, prefix, char
	localparam int V_BIT  = ENTRY_W - 1;
	localparam int C_LSB  = CODE_BITS + lzwc_pkg::BYTE_W;
	localparam int P_LSB  = lzwc_pkg::BYTE_W;

	logic [ENTRY_W-1:0] mem [TABLE_SIZE];
	logic [ENTRY_W-1:0] rd_q;

	logic [7:0]           ch_q;
	logic                 last_q;
	logic [CODE_BITS-1:0] cur_q;
	logic                 have_q;
	logic [CODE_BITS-1:0] nfc_q;
	logic [RW-1:0]        rem_q;
	logic [MK_W-1:0]      mk_q;
	logic [IDX_W-1:0]     idx_q, step_q, clr_q;
	logic [IDX_W-1:0]     tries_q;
	logic [lzwc_pkg::PACK_W-1:0] buf_q;
	logic [lzwc_pkg::CNT_W-1:0]  cnt_q;
	logic [lzwc_pkg::EMIT_W-1:0] emitted_q;
	logic                 out_valid_q;
	lzwc_pkg::out_item_t  out_q;

	logic [RW-1:0]        hash_val, divisor;
	logic [IDX_W-1:0]     idx_load, idx_next;
	logic [IDX_W:0]       wrap_sum;
	logic [CODE_BITS-1:0] end_code, put_code;
	logic [lzwc_pkg::PACK_W-1:0] put_bits;
	logic                 cap, out_free, do_shift, do_out, byte_last, table_room;

	assign end_code = {CODE_BITS{1'b1}};
	assign hash_val = (RW'(src_item.data_byte) << HASH_SHIFT) ^ RW'(cur_q);
	assign divisor  = RW'(TABLE_SIZE) << mk_q;
	assign idx_load = rem_q[IDX_W-1:0];
	assign wrap_sum = {1'b0, idx_q} + (IDX_W+1)'(TABLE_SIZE) - {1'b0, step_q};
	assign idx_next = (idx_q >= step_q) ? (idx_q - step_q) : wrap_sum[IDX_W-1:0];
	assign table_room = (nfc_q != end_code);

	always_comb begin
		case (cmd.code_sel)
			lzwc_pkg::SEL_CUR: put_code = cur_q;
			lzwc_pkg::SEL_END: put_code = end_code;
			default:           put_code = '0;
		endcase
	end
	assign put_bits = {put_code, {PAD_W{1'b0}}} >> cnt_q;

	assign cap       = (emitted_q == lzwc_pkg::EMIT_W'(lzwc_pkg::MAX_OUT));
	assign out_free  = !out_valid_q || dst_ready;
	assign do_shift  = cmd.drain && (cnt_q >= lzwc_pkg::CNT_W'(8)) && (cap || out_free);
	assign do_out    = do_shift && !cap;
	assign byte_last = cmd.in_flush &&
		((emitted_q == lzwc_pkg::EMIT_W'(lzwc_pkg::MAX_OUT - 1)) ||
		 (cmd.tail && cnt_q < lzwc_pkg::CNT_W'(16)));

	// dictionary memory
	always_ff @(posedge clk) begin
		if (cmd.clr_step) mem[clr_q] <= '0;
		else if (cmd.add && table_room) mem[idx_q] <= {1'b1, nfc_q, cur_q, ch_q};
		if (cmd.mem_rd) rd_q <= mem[idx_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ch_q   <= src_item.data_byte;
			last_q <= src_item.last_byte;
			rem_q  <= hash_val;
		end else if (cmd.mod_step && rem_q >= divisor) begin
			rem_q <= rem_q - divisor;
		end
		if (cmd.probe_load) begin
			idx_q  <= idx_load;
			step_q <= (idx_load == '0) ? IDX_W'(1) : IDX_W'(TABLE_SIZE) - idx_load;
		end else if (cmd.probe_adv) begin
			idx_q <= idx_next;
		end
		if (do_out) out_q <= '{out_byte: buf_q[31:24], out_last: byte_last};
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			have_q      <= 1'b0;
			nfc_q       <= CODE_BITS'(lzwc_pkg::FIRST_FREE);
			mk_q        <= '0;
			tries_q     <= '0;
			clr_q       <= '0;
			buf_q       <= '0;
			cnt_q       <= '0;
			emitted_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				emitted_q <= '0;
				mk_q      <= MK_W'(QB - 1);
				if (!have_q) begin
					cur_q  <= CODE_BITS'(src_item.data_byte);
					have_q <= 1'b1;
				end
			end else if (cmd.mod_step && mk_q != '0) begin
				mk_q <= mk_q - MK_W'(1);
			end
			if (cmd.probe_load) tries_q <= '0;
			else if (cmd.probe_adv) tries_q <= tries_q + IDX_W'(1);
			if (cmd.clr_step)
				clr_q <= (clr_q == IDX_W'(TABLE_SIZE - 1)) ? '0 : clr_q + IDX_W'(1);
			if (cmd.add && table_room) nfc_q <= nfc_q + CODE_BITS'(1);
			if (cmd.hit) cur_q <= rd_q[C_LSB +: CODE_BITS];
			if (cmd.cur_from_ch) cur_q <= CODE_BITS'(ch_q);
			if (cmd.put) begin
				buf_q <= buf_q | put_bits;
				cnt_q <= cnt_q + lzwc_pkg::CNT_W'(CODE_BITS);
			end else if (do_shift) begin
				buf_q <= buf_q << 8;
				cnt_q <= cnt_q - lzwc_pkg::CNT_W'(8);
				if (!cap) emitted_q <= emitted_q + lzwc_pkg::EMIT_W'(1);
			end
			if (do_out) out_valid_q <= 1'b1;
			else if (dst_ready) out_valid_q <= 1'b0;
			if (cmd.stream_reset) begin
				cur_q  <= '0;
				have_q <= 1'b0;
				nfc_q  <= CODE_BITS'(lzwc_pkg::FIRST_FREE);
				buf_q  <= '0;
				cnt_q  <= '0;
			end
		end
	end

	assign dst_item  = out_q;
	assign dst_valid = out_valid_q;

	assign status.in_last         = src_item.last_byte;
	assign status.have_prefix     = have_q;
	assign status.last            = last_q;
	assign status.mod_done        = (mk_q == '0);
	assign status.rd_valid        = rd_q[V_BIT];
	assign status.rd_match        = (rd_q[P_LSB-1:0] == ch_q) &&
		(rd_q[P_LSB +: CODE_BITS] == cur_q);
	assign status.probe_exhausted = (tries_q == IDX_W'(TABLE_SIZE - 1));
	assign status.drain_pending   = (cnt_q >= lzwc_pkg::CNT_W'(8));
	assign status.clr_done        = (clr_q == IDX_W'(TABLE_SIZE - 1));

endmodule

### design/lzw_compressor.sv
`timescale 1ns / 1ps
// lzw_compressor: top level, controller plus datapath
// depends on lzwc_pkg, lzwc_ctrl, lzwc_dp
// LZW compressor with a hashed dictionary of TABLE_SIZE entries in one
// single-port-read memory and fixed CODE_BITS-wide codes packed MSB first into
// bytes. One byte is taken at a time. A byte that extends the current string
// is accepted, then passes the hash remainder unit (one compare and subtract a
// cycle), one probe load and one dictionary probe after another (read, then
// compare). A miss adds a put of the current code and a drain of the complete
// output bytes; the final byte adds the flush of the current code, the end
// code and zero padding. After reset and after every stream end the
// dictionary is swept, one entry a cycle, during which no byte is taken. The
// output register lets a finished byte wait while the next one is formed.
module lzw_compressor #(
	parameter int CODE_BITS  = 12,
	parameter int TABLE_SIZE = 5021,
	parameter int HASH_SHIFT = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_ready,
	input  lzwc_pkg::in_item_t  src_item,
	output logic                dst_valid,
	input  logic                dst_ready,
	output lzwc_pkg::out_item_t dst_item
);

	lzwc_pkg::cmd_t    cmd;
	lzwc_pkg::status_t status;

	lzwc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.status    (status),
		.cmd       (cmd)
	);

	lzwc_dp #(
		.CODE_BITS  (CODE_BITS),
		.TABLE_SIZE (TABLE_SIZE),
		.HASH_SHIFT (HASH_SHIFT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_item  (src_item),
		.dst_item  (dst_item),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
